// ----- rtl/scan_block_deframer_rle_decoder_macros.svh -----
// assertion macros for the scan block deframer checker
// no dependencies; included by the checker file only
`ifndef SCAN_BLOCK_DEFRAMER_RLE_DECODER_MACROS_SVH
`define SCAN_BLOCK_DEFRAMER_RLE_DECODER_MACROS_SVH

// same-cycle implication
`define SBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define SBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/sbd_pkg.sv -----
// shared types and constants for the scan block deframer
// no dependencies
package sbd_pkg;

   localparam int ResultBytes      = 4;
   localparam int LaneBytesDefault = 4;
   localparam int HeaderBytes      = 12;
   localparam int FrameBytes       = 10;
   localparam int MaxRepeat        = 129;

   localparam logic [7:0] TypeEndData  = 8'h80;
   localparam logic [7:0] TypeEndFrame = 8'h82;
   localparam logic [7:0] TypeJpeg     = 8'h64;
   localparam logic [7:0] TypeRle      = 8'h42;
   localparam logic [7:0] TypeRaw      = 8'h40;
   localparam logic [7:0] RepeatBase   = 8'h80;

   typedef enum logic [1:0] {
      EV_DATA      = 2'd0,
      EV_END_DATA  = 2'd1,
      EV_END_FRAME = 2'd2,
      EV_BAD_TYPE  = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      KIND_RAW  = 2'd0,
      KIND_RLE  = 2'd1,
      KIND_JPEG = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_LIT  = 2'd1,
      PH_REP  = 2'd2
   } phase_type;

   typedef struct packed {
      logic accept;
      logic emit_run;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic run_start;
      logic run_final;
   } ctl_sts_type;

endpackage

// ----- rtl/scan_block_deframer_rle_decoder.sv -----
// scan block deframer with packbits run-length decoding, top level
// an accepted input beat's result is loaded into the result register; the first
// result beat of a repeat run is loaded after the controller enters its run state
// throughput: one input beat per cycle while the result register is free; a repeat
// run holds input off while the run counter emits its result beats
// reset: synchronous, active high; clears header, run state and result valid
// depends on sbd_pkg, sbd_ctrl, sbd_datapath
module scan_block_deframer_rle_decoder #(
   parameter int LANE_BYTES = sbd_pkg::LaneBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_page_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [2:0] rsp_byte_count,
   output logic [1:0] rsp_block_kind,
   output logic [1:0] rsp_event_res,
   output logic       rsp_last
);
   import sbd_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   sbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sbd_datapath #(
      .LANE_BYTES (LANE_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_in_byte      (req_in_byte),
      .req_page_restart (req_page_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte0    (rsp_out_byte0),
      .rsp_out_byte1    (rsp_out_byte1),
      .rsp_out_byte2    (rsp_out_byte2),
      .rsp_out_byte3    (rsp_out_byte3),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_block_kind   (rsp_block_kind),
      .rsp_event_res    (rsp_event_res),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- rtl/sbd_ctrl.sv -----
// controller state machine: input acceptance and repeat run sequencing
// depends on sbd_pkg
module sbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sbd_pkg::ctl_sts_type sts,
   output sbd_pkg::ctl_cmd_type cmd
);
   import sbd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } ctl_state_type;

   ctl_state_type state_ff, state_in;

   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.emit_run = 1'b0;
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept && sts.run_start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.emit_run = sts.out_free;
            if (sts.out_free && sts.run_final) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/sbd_datapath.sv -----
// datapath: header parsing, run-length state, repeat counter, result register
// depends on sbd_pkg
module sbd_datapath #(
   parameter int LANE_BYTES = sbd_pkg::LaneBytesDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sbd_pkg::ctl_cmd_type cmd,
   output sbd_pkg::ctl_sts_type sts,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_page_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte0,
   output logic [7:0]           rsp_out_byte1,
   output logic [7:0]           rsp_out_byte2,
   output logic [7:0]           rsp_out_byte3,
   output logic [2:0]           rsp_byte_count,
   output logic [1:0]           rsp_block_kind,
   output logic [1:0]           rsp_event_res,
   output logic                 rsp_last
);
   import sbd_pkg::*;

   localparam int LaneEff = (LANE_BYTES < 1) ? 1 :
                            ((LANE_BYTES > ResultBytes) ? ResultBytes : LANE_BYTES);
   localparam logic [2:0] Lane       = 3'(LaneEff);
   localparam logic [3:0] LenLowPos  = 4'(HeaderBytes - 2);
   localparam logic [3:0] InPayload  = 4'(HeaderBytes);
   localparam logic [3:0] FramePos   = 4'(FrameBytes);
   localparam logic [8:0] RepTop     = 9'd257;
   localparam logic [8:0] RepMax     = 9'(MaxRepeat);

   logic [3:0]  hp_ff, hp_in, hp_e, hp_nx;
   logic [7:0]  ty_ff, ty_in, ty_e;
   logic [7:0]  ll_ff, ll_in, ll_e;
   logic [15:0] pr_ff, pr_in, pr_e, pr_dec;
   phase_type   ph_ff, ph_in, ph_e;
   logic [7:0]  lit_ff, lit_in, lit_e, lit_dec;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  rep_ff, rep_in;
   logic [8:0]  rep_raw;
   logic [2:0]  chunk;
   logic [15:0] len;
   logic        known;

   logic        valid_ff, valid_in;
   logic [7:0]  ob_ff [ResultBytes];
   logic [7:0]  ob_in [ResultBytes];
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  ev_ff, ev_in;
   logic        last_ff, last_in;
   logic        load;
   logic        run_start;
   logic [7:0]  b;

   assign b     = req_in_byte;
   assign chunk = (rem_ff < {5'd0, Lane}) ? rem_ff[2:0] : Lane;

   assign sts.out_free  = !valid_ff || rsp_ready;
   assign sts.run_final = rem_ff <= {5'd0, Lane};
   assign sts.run_start = run_start;

   always_comb begin
      hp_e   = req_page_restart ? 4'd0  : hp_ff;
      ty_e   = req_page_restart ? 8'd0  : ty_ff;
      ll_e   = req_page_restart ? 8'd0  : ll_ff;
      pr_e   = req_page_restart ? 16'd0 : pr_ff;
      ph_e   = req_page_restart ? PH_CTRL : ph_ff;
      lit_e  = req_page_restart ? 8'd0  : lit_ff;
      hp_nx  = hp_e + 4'd1;
      pr_dec = pr_e - 16'd1;
      lit_dec = lit_e - 8'd1;
      len    = {b, ll_e};
      known  = (ty_e == TypeRaw) || (ty_e == TypeRle) || (ty_e == TypeJpeg);
      rep_raw = RepTop - {1'b0, lit_e};
      if (rep_raw > RepMax) begin
         rep_raw = RepMax;
      end
   end

   always_comb begin
      hp_in  = hp_ff;
      ty_in  = ty_ff;
      ll_in  = ll_ff;
      pr_in  = pr_ff;
      ph_in  = ph_ff;
      lit_in = lit_ff;
      rem_in = rem_ff;
      rep_in = rep_ff;
      run_start = 1'b0;
      load    = 1'b0;
      cnt_in  = 3'd0;
      kind_in = KIND_RAW;
      ev_in   = EV_DATA;
      last_in = 1'b1;
      for (int i = 0; i < ResultBytes; i++) begin
         ob_in[i] = 8'd0;
      end

      if (cmd.accept) begin
         hp_in  = hp_e;
         ty_in  = ty_e;
         ll_in  = ll_e;
         pr_in  = pr_e;
         ph_in  = ph_e;
         lit_in = lit_e;
         if (hp_e >= InPayload) begin
            if (ty_e == TypeRaw || ty_e == TypeJpeg) begin
               load     = 1'b1;
               cnt_in   = 3'd1;
               ob_in[0] = b;
               kind_in  = (ty_e == TypeRaw) ? KIND_RAW : KIND_JPEG;
            end else if (ty_e == TypeRle) begin
               case (ph_e)
                  PH_LIT: begin
                     load     = 1'b1;
                     cnt_in   = 3'd1;
                     ob_in[0] = b;
                     kind_in  = KIND_RLE;
                     lit_in   = lit_dec;
                     if (lit_dec == 8'd0) begin
                        ph_in = PH_CTRL;
                     end
                  end
                  PH_REP: begin
                     run_start = 1'b1;
                     rem_in    = rep_raw[7:0];
                     rep_in    = b;
                     ph_in     = PH_CTRL;
                     lit_in    = 8'd0;
                  end
                  default: begin
                     if (b < RepeatBase) begin
                        lit_in = b + 8'd1;
                        ph_in  = PH_LIT;
                     end else begin
                        lit_in = b;
                        ph_in  = PH_REP;
                     end
                  end
               endcase
            end
            pr_in = pr_dec;
            if (pr_dec == 16'd0) begin
               hp_in  = 4'd0;
               ty_in  = 8'd0;
               ph_in  = PH_CTRL;
               lit_in = 8'd0;
            end
         end else if (hp_e == 4'd0) begin
            if (b == TypeEndData) begin
               load  = 1'b1;
               ev_in = EV_END_DATA;
            end else begin
               ty_in = b;
               hp_in = 4'd1;
            end
         end else if (ty_e == TypeEndFrame) begin
            hp_in = hp_nx;
            if (hp_nx >= FramePos) begin
               load  = 1'b1;
               ev_in = EV_END_FRAME;
               hp_in = 4'd0;
               ty_in = 8'd0;
            end
         end else begin
            if (hp_e == LenLowPos) begin
               ll_in = b;
            end
            hp_in = hp_nx;
            if (hp_nx >= InPayload) begin
               ph_in  = PH_CTRL;
               lit_in = 8'd0;
               if (!known) begin
                  load  = 1'b1;
                  ev_in = EV_BAD_TYPE;
                  hp_in = 4'd0;
                  ty_in = 8'd0;
               end else if (len == 16'd0) begin
                  hp_in = 4'd0;
                  ty_in = 8'd0;
               end else begin
                  pr_in = len;
                  hp_in = InPayload;
               end
            end
         end
      end

      if (cmd.emit_run) begin
         load    = 1'b1;
         cnt_in  = chunk;
         kind_in = KIND_RLE;
         last_in = rem_ff == {5'd0, chunk};
         rem_in  = rem_ff - {5'd0, chunk};
         for (int i = 0; i < ResultBytes; i++) begin
            ob_in[i] = (3'(i) < chunk) ? rep_ff : 8'd0;
         end
      end

      valid_in = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff    <= 4'd0;
         ty_ff    <= 8'd0;
         ll_ff    <= 8'd0;
         pr_ff    <= 16'd0;
         ph_ff    <= PH_CTRL;
         lit_ff   <= 8'd0;
         rem_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         hp_ff    <= hp_in;
         ty_ff    <= ty_in;
         ll_ff    <= ll_in;
         pr_ff    <= pr_in;
         ph_ff    <= ph_in;
         lit_ff   <= lit_in;
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_ff <= rep_in;
      if (load) begin
         ob_ff   <= ob_in;
         cnt_ff  <= cnt_in;
         kind_ff <= kind_in;
         ev_ff   <= ev_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte0  = ob_ff[0];
   assign rsp_out_byte1  = ob_ff[1];
   assign rsp_out_byte2  = ob_ff[2];
   assign rsp_out_byte3  = ob_ff[3];
   assign rsp_byte_count = cnt_ff;
   assign rsp_block_kind = kind_ff;
   assign rsp_event_res  = ev_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- rtl/sbd_checker.sv -----
// port-level checker for the scan block deframer, bound to the top level
// depends on sbd_pkg and the assertion macro header
`include "scan_block_deframer_rle_decoder_macros.svh"

module sbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte0,
   input logic [7:0] rsp_out_byte1,
   input logic [7:0] rsp_out_byte3,
   input logic [2:0] rsp_byte_count,
   input logic [1:0] rsp_block_kind,
   input logic [1:0] rsp_event_res,
   input logic       rsp_last
);
   import sbd_pkg::*;

   `SBD_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `SBD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte0) && $stable(rsp_byte_count) && $stable(rsp_last))
   `SBD_ASSERT_IMP(a_event_empty, clock, reset, rsp_valid && rsp_event_res != EV_DATA, rsp_byte_count == 3'd0 && rsp_block_kind == KIND_RAW && rsp_out_byte0 == 8'd0 && rsp_last)
   `SBD_ASSERT_IMP(a_data_count, clock, reset, rsp_valid && rsp_event_res == EV_DATA, rsp_byte_count != 3'd0 && rsp_byte_count <= 3'd4 && (rsp_byte_count == 3'd4 || rsp_out_byte3 == 8'd0) && (rsp_byte_count != 3'd1 || rsp_out_byte1 == 8'd0))

endmodule

bind scan_block_deframer_rle_decoder sbd_checker u_sbd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte0  (rsp_out_byte0),
   .rsp_out_byte1  (rsp_out_byte1),
   .rsp_out_byte3  (rsp_out_byte3),
   .rsp_byte_count (rsp_byte_count),
   .rsp_block_kind (rsp_block_kind),
   .rsp_event_res  (rsp_event_res),
   .rsp_last       (rsp_last)
);

// ----- tb/sv/tb_scan_block_deframer_rle_decoder.sv -----
// self-checking testbench for the scan block deframer and run-length decoder:
// a directed table, then random block streams, checked beat by beat
// depends on sbd_pkg and scan_block_deframer_rle_decoder
module tb_scan_block_deframer_rle_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import sbd_pkg::*;

   localparam int Lane = (LaneBytesDefault < 1) ? 1 :
                         (LaneBytesDefault > ResultBytes) ? ResultBytes : LaneBytesDefault;
   localparam int RandomItems = 450;
   localparam int MaxShown    = 10;
   localparam int HoldCycles  = 300;

   typedef struct packed {
      logic [7:0] b0, b1, b2, b3;
      logic [2:0] cnt;
      kind_type   kind;
      event_type  ev;
      logic       last;
   } decoded_beat_t;

   typedef struct packed {
      logic [7:0]    data;
      logic          restart;
      logic          typed;
      decoded_beat_t want;
   } stim_row_t;

   localparam decoded_beat_t NoBeat = '0;
   localparam decoded_beat_t EndDataBeat =
      '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, KIND_RAW, EV_END_DATA, 1'b1};
   localparam decoded_beat_t EndFrameBeat =
      '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, KIND_RAW, EV_END_FRAME, 1'b1};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_page_restart;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [7:0] rsp_out_byte3;
   logic [2:0] rsp_byte_count;
   logic [1:0] rsp_block_kind;
   logic [1:0] rsp_event_res;
   logic       rsp_last;

   // end of data, end of frame, then a run-length block with a full repeat
   stim_row_t directed_rows [27] = '{
      '{8'h80, 1'b1, 1'b1, EndDataBeat},
      '{TypeEndFrame, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat},
      '{8'h55, 1'b0, 1'b0, NoBeat},
      '{8'haa, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat},
      '{8'h01, 1'b0, 1'b0, NoBeat},
      '{8'hfe, 1'b0, 1'b0, NoBeat},
      '{8'h80, 1'b0, 1'b1, EndFrameBeat},
      '{TypeRle, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat},
      '{8'h04, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'h80, 1'b0, 1'b0, NoBeat},
      '{8'ha5, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hff, 1'b0, 1'b0, NoBeat}
   };

   stim_row_t     stim_q[$];
   decoded_beat_t step_beats[$];
   decoded_beat_t due_beats[$];

   // decoder shadow state
   logic [3:0]  hdr_pos;
   logic [7:0]  blk_type;
   logic [7:0]  len_lo;
   logic [15:0] pay_left;
   phase_type   phase;
   logic [7:0]  lit_left;

   int errors        = 0;
   int beats_seen    = 0;
   int beats_sent    = 0;
   int repeat_runs   = 0;
   int header_events = 0;

   scan_block_deframer_rle_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_page_restart (req_page_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte0    (rsp_out_byte0),
      .rsp_out_byte1    (rsp_out_byte1),
      .rsp_out_byte2    (rsp_out_byte2),
      .rsp_out_byte3    (rsp_out_byte3),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_block_kind   (rsp_block_kind),
      .rsp_event_res    (rsp_event_res),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void restart_decoder();
      hdr_pos  = 4'd0;
      blk_type = 8'h00;
      len_lo   = 8'h00;
      pay_left = 16'h0000;
      phase    = PH_CTRL;
      lit_left = 8'h00;
   endfunction

   function automatic void emit(logic [7:0] b, int n, kind_type k, event_type ev);
      decoded_beat_t r;
      r      = '0;
      r.b0   = (n > 0) ? b : 8'h00;
      r.b1   = (n > 1) ? b : 8'h00;
      r.b2   = (n > 2) ? b : 8'h00;
      r.b3   = (n > 3) ? b : 8'h00;
      r.cnt  = 3'(n);
      r.kind = k;
      r.ev   = ev;
      if (ev != EV_DATA) header_events++;
      step_beats.push_back(r);
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic restart);
      int            rem;
      int            n;
      logic [15:0]   len;
      decoded_beat_t tail;
      step_beats.delete();
      if (restart) restart_decoder();
      if (hdr_pos >= 4'(HeaderBytes)) begin
         if (blk_type == TypeRaw) begin
            emit(b, 1, KIND_RAW, EV_DATA);
         end else if (blk_type == TypeJpeg) begin
            emit(b, 1, KIND_JPEG, EV_DATA);
         end else if (blk_type == TypeRle) begin
            case (phase)
               PH_LIT: begin
                  emit(b, 1, KIND_RLE, EV_DATA);
                  lit_left = lit_left - 8'd1;
                  if (lit_left == 8'd0) phase = PH_CTRL;
               end
               PH_REP: begin
                  rem = 257 - int'(lit_left);
                  if (rem > MaxRepeat) rem = MaxRepeat;
                  repeat_runs++;
                  while (rem > 0) begin
                     n = (rem < Lane) ? rem : Lane;
                     emit(b, n, KIND_RLE, EV_DATA);
                     rem -= n;
                  end
                  phase    = PH_CTRL;
                  lit_left = 8'h00;
               end
               default: begin
                  if (b < RepeatBase) begin
                     lit_left = b + 8'd1;
                     phase    = PH_LIT;
                  end else begin
                     lit_left = b;
                     phase    = PH_REP;
                  end
               end
            endcase
         end
         pay_left = pay_left - 16'd1;
         if (pay_left == 16'd0) begin
            hdr_pos  = 4'd0;
            blk_type = 8'h00;
            phase    = PH_CTRL;
            lit_left = 8'h00;
         end
      end else if (hdr_pos == 4'd0) begin
         if (b == TypeEndData) begin
            emit(8'h00, 0, KIND_RAW, EV_END_DATA);
         end else begin
            blk_type = b;
            hdr_pos  = 4'd1;
         end
      end else if (blk_type == TypeEndFrame) begin
         hdr_pos++;
         if (hdr_pos >= 4'(FrameBytes)) begin
            emit(8'h00, 0, KIND_RAW, EV_END_FRAME);
            hdr_pos  = 4'd0;
            blk_type = 8'h00;
         end
      end else begin
         if (hdr_pos == 4'(HeaderBytes - 2)) len_lo = b;
         hdr_pos++;
         if (hdr_pos >= 4'(HeaderBytes)) begin
            len      = {b, len_lo};
            phase    = PH_CTRL;
            lit_left = 8'h00;
            if (blk_type != TypeRaw && blk_type != TypeRle && blk_type != TypeJpeg) begin
               emit(8'h00, 0, KIND_RAW, EV_BAD_TYPE);
               hdr_pos  = 4'd0;
               blk_type = 8'h00;
            end else if (len == 16'd0) begin
               hdr_pos  = 4'd0;
               blk_type = 8'h00;
            end else begin
               pay_left = len;
               hdr_pos  = 4'(HeaderBytes);
            end
         end
      end
      if (step_beats.size() > 0) begin
         tail      = step_beats.pop_back();
         tail.last = 1'b1;
         step_beats.push_back(tail);
      end
   endfunction

   function automatic void add_beat(logic [7:0] b);
      stim_row_t s;
      s         = '0;
      s.data    = b;
      s.restart = ($urandom_range(0, 63) == 0);
      stim_q.push_back(s);
   endfunction

   // mostly well-formed blocks with random content, some noise
   function automatic void add_block();
      int         pick;
      int         len;
      int         n;
      logic [7:0] t;
      logic [7:0] body[$];
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         add_beat(TypeEndData);
      end else if (pick < 12) begin
         add_beat(TypeEndFrame);
         repeat (FrameBytes - 1) add_beat(8'($urandom));
      end else if (pick < 20) begin
         do t = 8'($urandom);
         while (t == TypeRaw || t == TypeRle || t == TypeJpeg ||
                t == TypeEndData || t == TypeEndFrame);
         add_beat(t);
         repeat (HeaderBytes - 1) add_beat(8'($urandom));
      end else if (pick >= 92) begin
         repeat ($urandom_range(1, 3)) add_beat(8'($urandom));
      end else begin
         if (pick < 45) begin
            len = (pick < 26) ? 0 : $urandom_range(1, 12);
            case ($urandom_range(0, 2))
               0: t = TypeRaw;
               1: t = TypeJpeg;
               default: t = TypeRle;
            endcase
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 140) : $urandom_range(2, 20);
            t   = TypeRle;
         end
         add_beat(t);
         repeat (HeaderBytes - 3) add_beat(8'($urandom));
         add_beat(8'(len));
         add_beat(8'(len >> 8));
         if (t == TypeRle) begin
            while (body.size() < len) begin
               if ($urandom_range(0, 1) == 1) begin
                  n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
                  body.push_back(8'(n));
                  repeat (n + 1) body.push_back(8'($urandom));
               end else begin
                  body.push_back(8'($urandom_range(128, 255)));
                  body.push_back(8'($urandom));
               end
            end
         end else begin
            repeat (len) body.push_back(8'($urandom));
         end
         for (int i = 0; i < len; i++) add_beat(body[i]);
      end
   endfunction

   function automatic void report(string what, decoded_beat_t want, decoded_beat_t got);
      errors++;
      if (errors <= MaxShown) begin
         $display("%0t %s: want %h %h %h %h n=%0d k=%0d e=%0d l=%0d",
                  $time, what, want.b0, want.b1, want.b2, want.b3,
                  want.cnt, want.kind, want.ev, want.last);
         $display("%0t %s:  got %h %h %h %h n=%0d k=%0d e=%0d l=%0d",
                  $time, what, got.b0, got.b1, got.b2, got.b3,
                  got.cnt, got.kind, got.ev, got.last);
      end
   endfunction

   // result check first, then the expectation of the beat taken this edge
   always @(posedge clock) begin
      decoded_beat_t got;
      decoded_beat_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_byte3,
                 rsp_byte_count, kind_type'(rsp_block_kind),
                 event_type'(rsp_event_res), rsp_last};
         beats_seen++;
         if (due_beats.size() == 0) begin
            report("unexpected beat", NoBeat, got);
         end else begin
            want = due_beats.pop_front();
            if (got !== want) report("mismatch", want, got);
         end
      end
      if (!reset && req_valid && req_ready) begin
         decode_byte(req_in_byte, req_page_restart);
         if (stim_q[beats_sent].typed) begin
            due_beats.push_back(stim_q[beats_sent].want);
         end else begin
            foreach (step_beats[k]) due_beats.push_back(step_beats[k]);
         end
         beats_sent++;
      end
   end

   initial begin
      int gap;
      bit calm;
      int drain;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = 8'h00;
      req_page_restart = 1'b0;
      calm             = 1'b0;
      restart_decoder();
      foreach (directed_rows[r]) stim_q.push_back(directed_rows[r]);
      while (stim_q.size() < $size(directed_rows) + RandomItems) add_block();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_q[i]) begin
         if ($urandom_range(0, 29) == 0) calm = !calm;
         gap = calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid        <= 1'b1;
         req_in_byte      <= stim_q[i].data;
         req_page_restart <= stim_q[i].restart;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
      req_valid <= 1'b0;
      drain = 0;
      while (due_beats.size() > 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (40) @(posedge clock);
      if (due_beats.size() > 0) begin
         $display("%0d expected beats never arrived", due_beats.size());
         errors += due_beats.size();
      end
      $display("covered %0d input beats (%0d directed) and %0d result beats",
               beats_sent, $size(directed_rows), beats_seen);
      $display("%0d repeat runs expanded, %0d end/error events, %0d failures",
               repeat_runs, header_events, errors);
      if (errors == 0) begin
         $display("tb_scan_block_deframer_rle_decoder: done, clean");
      end else begin
         $display("tb_scan_block_deframer_rle_decoder: done, errors");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off to back up the input
   initial begin
      int gap;
      bit calm;
      bit held;
      rsp_ready = 1'b0;
      calm      = 1'b0;
      held      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && beats_seen >= 80) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         if ($urandom_range(0, 29) == 0) calm = !calm;
         gap = calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      #5ms;
      $display("timeout at %0t", $time);
      $display("tb_scan_block_deframer_rle_decoder: done, errors");
      $finish;
   end

endmodule

// ----- scan_block_deframer_rle_decoder.f -----
+incdir+rtl
rtl/sbd_pkg.sv
rtl/sbd_ctrl.sv
rtl/sbd_datapath.sv
rtl/scan_block_deframer_rle_decoder.sv
rtl/sbd_checker.sv
tb/sv/tb_scan_block_deframer_rle_decoder.sv
